// File: rtl/pbwf_pkg.sv
package pbwf_pkg;

    typedef enum logic [4:0] {
        PH_TAG    = 5'b00001,
        PH_VARINT = 5'b00010,
        PH_LEN    = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_SKIP   = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_VARINT = 3'd1,
        KIND_BYTE   = 3'd2,
        KIND_EMPTY  = 3'd3,
        KIND_TRUNC  = 3'd4,
        KIND_BAD    = 3'd5
    } kind_t;

    localparam logic [2:0] WIRE_VARINT = 3'd0;
    localparam logic [2:0] WIRE_I64    = 3'd1;
    localparam logic [2:0] WIRE_LEN    = 3'd2;
    localparam logic [2:0] WIRE_I32    = 3'd5;

    localparam logic [3:0] GRP_FULL    = 4'd9;
    localparam logic [3:0] GRP_MAX     = 4'd10;
    localparam logic [63:0] I64_BYTES  = 64'd8;
    localparam logic [63:0] I32_BYTES  = 64'd4;

    typedef struct packed {
        phase_t      phase;
        logic [63:0] acc;
        logic [3:0]  grp_cnt;
        logic [31:0] field;
        logic [2:0]  wire_t;
        logic [63:0] bytes_left;
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] field;
        logic [2:0]  wire_t;
        logic [63:0] value;
        logic        field_end;
        logic        buffer_end;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:      PH_TAG,
        acc:        64'd0,
        grp_cnt:    4'd0,
        field:      32'd0,
        wire_t:     3'd0,
        bytes_left: 64'd0
    };

endpackage

// File: rtl/pbwf_step.sv
module pbwf_step (
    input  pbwf_pkg::state_t  cur,
    input  logic [7:0]        data_byte,
    input  logic              eob,
    output pbwf_pkg::state_t  nxt,
    output pbwf_pkg::result_t res
);
    import pbwf_pkg::*;

    logic [5:0]  grp_shift;
    logic [63:0] merged;
    logic [3:0]  grp_inc;
    logic        done;
    logic        last_byte;

    assign grp_shift = 6'({2'b00, cur.grp_cnt} * 6'd7);
    assign grp_inc   = (cur.grp_cnt < GRP_MAX) ? cur.grp_cnt + 4'd1 : cur.grp_cnt;
    assign done      = eob || !data_byte[7];
    assign last_byte = (cur.bytes_left[63:1] == 63'd0);

    always_comb
    begin
        if (cur.grp_cnt < GRP_FULL)
        begin
            merged = cur.acc | ({57'd0, data_byte[6:0]} << grp_shift);
        end
        else if (cur.grp_cnt == GRP_FULL)
        begin
            merged = cur.acc | {data_byte[0], 63'd0};
        end
        else
        begin
            merged = cur.acc;
        end
    end

    always_comb
    begin
        nxt            = cur;
        res.kind       = KIND_NONE;
        res.value      = 64'd0;
        res.field_end  = 1'b0;
        res.buffer_end = eob;

        case (cur.phase)
            PH_TAG:
            begin
                nxt.acc     = merged;
                nxt.grp_cnt = grp_inc;
                if (done)
                begin
                    nxt.field   = merged[34:3];
                    nxt.wire_t  = merged[2:0];
                    nxt.acc     = 64'd0;
                    nxt.grp_cnt = 4'd0;
                    if (merged[2:0] == WIRE_VARINT)
                    begin
                        if (eob)
                        begin
                            res.kind      = KIND_VARINT;
                            res.field_end = 1'b1;
                        end
                        else
                        begin
                            nxt.phase = PH_VARINT;
                        end
                    end
                    else if (merged[2:0] inside {WIRE_I64, WIRE_I32})
                    begin
                        if (eob)
                        begin
                            res.kind = KIND_TRUNC;
                        end
                        else
                        begin
                            nxt.bytes_left = (merged[2:0] == WIRE_I64) ? I64_BYTES : I32_BYTES;
                            nxt.phase      = PH_DATA;
                        end
                    end
                    else if (merged[2:0] == WIRE_LEN)
                    begin
                        if (eob)
                        begin
                            res.kind      = KIND_EMPTY;
                            res.field_end = 1'b1;
                        end
                        else
                        begin
                            nxt.phase = PH_LEN;
                        end
                    end
                    else
                    begin
                        res.kind  = KIND_BAD;
                        nxt.phase = PH_SKIP;
                    end
                end
            end
            PH_VARINT:
            begin
                nxt.acc     = merged;
                nxt.grp_cnt = grp_inc;
                if (done)
                begin
                    res.kind      = KIND_VARINT;
                    res.value     = merged;
                    res.field_end = 1'b1;
                    nxt.acc       = 64'd0;
                    nxt.grp_cnt   = 4'd0;
                    nxt.phase     = PH_TAG;
                end
            end
            PH_LEN:
            begin
                nxt.acc     = merged;
                nxt.grp_cnt = grp_inc;
                if (done)
                begin
                    nxt.acc     = 64'd0;
                    nxt.grp_cnt = 4'd0;
                    if (merged == 64'd0)
                    begin
                        res.kind      = KIND_EMPTY;
                        res.field_end = 1'b1;
                        nxt.phase     = PH_TAG;
                    end
                    else if (eob)
                    begin
                        res.kind = KIND_TRUNC;
                    end
                    else
                    begin
                        nxt.bytes_left = merged;
                        nxt.phase      = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (last_byte)
                begin
                    res.kind       = KIND_BYTE;
                    res.value      = {56'd0, data_byte};
                    res.field_end  = 1'b1;
                    nxt.bytes_left = 64'd0;
                    nxt.phase      = PH_TAG;
                end
                else if (eob)
                begin
                    res.kind = KIND_TRUNC;
                end
                else
                begin
                    res.kind       = KIND_BYTE;
                    res.value      = {56'd0, data_byte};
                    nxt.bytes_left = cur.bytes_left - 64'd1;
                end
            end
            default:
            begin
            end
        endcase

        res.field  = (res.kind == KIND_NONE) ? 32'd0 : nxt.field;
        res.wire_t = (res.kind == KIND_NONE) ? 3'd0 : nxt.wire_t;

        if (eob)
        begin
            nxt = STATE_RESET;
        end
    end

endmodule

// File: rtl/protobuf_wire_field_parser.sv
// Protobuf wire-format field parser. One buffer byte enters per request and gives exactly
// one result request: the byte is captured in an input register, decoded against the parser
// state in a single pass and written to the result register, which drives the ports. With
// the result side not stalling, one byte is taken every cycle; the result register is the
// only point of back-pressure, and the input register can still take one byte while the
// previous result waits. No start-up time after reset.
module protobuf_wire_field_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [31:0] field_number,
    output logic [2:0]  wire_type,
    output logic [63:0] value,
    output logic        field_end,
    output logic        buffer_end
);
    import pbwf_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    logic [7:0] in_byte_reg;
    logic    in_eob_reg;
    logic    advance;
    logic    out_valid_reg;
    logic    out_valid_next;
    state_t  state_reg;
    state_t  state_next;
    result_t res_reg;
    result_t res_next;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign in_valid_next  = in_valid || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    pbwf_step u_step (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .eob       (in_eob_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= data_byte;
            in_eob_reg  <= end_of_buffer;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = res_reg.kind;
    assign field_number = res_reg.field;
    assign wire_type    = res_reg.wire_t;
    assign value        = res_reg.value;
    assign field_end    = res_reg.field_end;
    assign buffer_end   = res_reg.buffer_end;

    a_eob_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_eob_reg) |=> (state_reg == STATE_RESET))
        else $error("parser state not cleared after end of buffer");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.kind == KIND_NONE) |->
        (res_reg.field == 32'd0 && res_reg.wire_t == 3'd0 && res_reg.field_end == 1'b0))
        else $error("empty result carries field data");

    a_field_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.field_end) |->
        (res_reg.kind == KIND_VARINT || res_reg.kind == KIND_BYTE ||
         res_reg.kind == KIND_EMPTY))
        else $error("field end on a result that cannot close a field");

    a_grp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.grp_cnt <= GRP_MAX)
        else $error("varint group count out of range");

    a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.phase == PH_SKIP) |=> (res_reg.kind == KIND_NONE))
        else $error("result produced while skipping after a bad wire type");

endmodule
